@@ rtl/ssr_pkg.sv @@
// Shared types, constants and arithmetic helpers for the stereo reverb.
package ssr_pkg;

  localparam int unsigned MaxDelayDef     = 2048;
  localparam int unsigned NumCombsDef     = 4;
  localparam int unsigned NumAllpassesDef = 2;
  localparam int unsigned StereoOffsetDef = 23;

  localparam logic [15:0] DecayReset = 16'd40632;
  localparam int          DivShift   = 30;

  typedef enum logic [1:0] {
    REG_WET_GAIN   = 2'd0,
    REG_DECAY_GAIN = 2'd1,
    REG_MONO_MODE  = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_BYPASS,
    ST_C_RD,
    ST_C_MUL1,
    ST_C_MUL2,
    ST_C_WR,
    ST_DIV1,
    ST_DIV2,
    ST_A_RD,
    ST_A_WR,
    ST_MX1,
    ST_MX2,
    ST_MX3,
    ST_DONE
  } state_t;

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    if (v > 48'sd8388607) return 24'sh7FFFFF;
    if (v < -48'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic logic [13:0] comb_base(input logic [1:0] k);
    logic [13:0] b;
    case (k)
      2'd0:    b = 14'd1237;
      2'd1:    b = 14'd1381;
      2'd2:    b = 14'd1481;
      default: b = 14'd1601;
    endcase
    return b;
  endfunction

  function automatic logic [13:0] ap_base(input logic k);
    return k ? 14'd431 : 14'd601;
  endfunction

  // Right-channel lines are longer by the stereo offset; clamp to line size.
  function automatic logic [13:0] delay_len(input logic [13:0] base, input logic ch,
                                            input int unsigned offset,
                                            input int unsigned maxd);
    logic [14:0] len;
    len = {1'b0, base} + (ch ? 15'(offset) : 15'd0);
    if (len > 15'(maxd)) len = 15'(maxd);
    return len[13:0];
  endfunction

  // Add the scaled tail to a PCM sample, truncate toward zero, clamp.
  function automatic logic signed [15:0] mix_pcm(input logic signed [15:0] e,
                                                 input logic signed [57:0] t,
                                                 input logic half);
    logic signed [59:0] tot;
    logic signed [59:0] q;
    tot = half ? ((60'(e) <<< 37) + 60'(t)) : ((60'(e) <<< 36) + 60'(t));
    if (tot < 0) tot = tot + (half ? ((60'sd1 <<< 37) - 60'sd1) : ((60'sd1 <<< 36) - 60'sd1));
    q = half ? (tot >>> 37) : (tot >>> 36);
    if (q > 60'sd32767) return 16'sh7FFF;
    if (q < -60'sd32768) return 16'sh8000;
    return q[15:0];
  endfunction

endpackage

@@ rtl/stereo_schroeder_reverb_top.sv @@
// Stereo reverb top level: sequencer, filter datapath and delay-line memories.
// Each accepted item runs both channels through the comb and allpass delay
// lines held in two RAMs, one read or write per line step; each comb steps
// through its read, damp, feedback and write states. A frame with zero wet
// gain passes straight through and marks the lines for clearing; before the
// next frame with a nonzero wet gain the block sweeps both RAMs, one word a
// cycle, over every address of the wider RAM, taking no items meanwhile.
// Configuration writes are always ready. The output is registered, so the
// next item is taken while a result waits.
module stereo_schroeder_reverb_top import ssr_pkg::*; #(
  parameter int unsigned MAX_DELAY     = MaxDelayDef,
  parameter int unsigned NUM_COMBS     = NumCombsDef,
  parameter int unsigned NUM_ALLPASSES = NumAllpassesDef,
  parameter int unsigned STEREO_OFFSET = StereoOffsetDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [17:0] send_sample,
  input  logic signed [15:0] existing_left,
  input  logic signed [15:0] existing_right,
  input  logic               period_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] left_out,
  output logic signed [15:0] right_out,
  output logic               frame_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int PW   = $clog2(MAX_DELAY);
  localparam int CIW  = (NUM_COMBS > 1) ? $clog2(NUM_COMBS) : 1;
  localparam int AIW  = (NUM_ALLPASSES > 1) ? $clog2(NUM_ALLPASSES) : 1;
  localparam int IW   = (CIW > AIW) ? CIW : AIW;
  localparam int CAW  = 1 + CIW + PW;
  localparam int AAW  = 1 + AIW + PW;
  localparam int SW   = (CAW > AAW) ? CAW : AAW;
  localparam int SUMW = 24 + CIW + 1;
  localparam logic [30:0] DivRecip = 31'((64'd1 << DivShift) / NUM_COMBS);

  logic [15:0] wet_gain, decay_gain;
  logic        mono_mode;
  logic        needs_clear;
  state_t      state, state_next;
  logic        chan;
  logic [IW-1:0] idx;
  logic [SW-1:0] clr_addr;

  logic signed [17:0] send_r;
  logic signed [15:0] el_r, er_r;
  logic               last_r;

  logic [PW-1:0]      comb_pos  [2][NUM_COMBS];
  logic signed [23:0] comb_damp [2][NUM_COMBS];
  logic [PW-1:0]      ap_pos    [2][NUM_ALLPASSES];

  logic signed [23:0]     out_w, v, tail_l, tail_r;
  logic signed [40:0]     prod1, prod2, prodl, prodr;
  logic signed [SUMW-1:0] sum;
  logic [SUMW+30:0]       dprod;
  logic signed [57:0]     tot_l, tot_r;

  logic [CIW-1:0] cidx;
  logic [AIW-1:0] aidx;
  logic [PW-1:0]  cpos, apos;
  logic [13:0]    clen, alen;
  logic [PW:0]    cpinc, apinc;
  logic [PW-1:0]  cpos_next, apos_next;
  logic signed [23:0] x, cout, st_cur, st_new, fb, d, ap_o, ap_w;
  logic signed [24:0] diff;
  logic [SUMW-1:0] mag, q0, qn, r, q;
  logic signed [56:0] scl, scr;
  logic wet_on, accept, out_free, c_last, a_last;

  logic            c_we, a_we;
  logic [CAW-1:0]  c_waddr, c_addr;
  logic [AAW-1:0]  a_waddr, a_addr;
  logic [23:0]     c_wdata, a_wdata, c_rdata, a_rdata;

  assign cidx   = idx[CIW-1:0];
  assign aidx   = idx[AIW-1:0];
  assign cpos   = comb_pos[chan][cidx];
  assign apos   = ap_pos[chan][aidx];
  assign c_addr = {chan, cidx, cpos};
  assign a_addr = {chan, aidx, apos};
  assign clen   = delay_len(comb_base(2'(idx)), chan, STEREO_OFFSET, MAX_DELAY);
  assign alen   = delay_len(ap_base(1'(idx)), chan, STEREO_OFFSET, MAX_DELAY);
  assign cpinc  = {1'b0, cpos} + (PW+1)'(1);
  assign apinc  = {1'b0, apos} + (PW+1)'(1);
  assign cpos_next = (14'(cpinc) >= clen) ? '0 : cpinc[PW-1:0];
  assign apos_next = (14'(apinc) >= alen) ? '0 : apinc[PW-1:0];
  assign c_last = (idx == IW'(NUM_COMBS - 1));
  assign a_last = (idx == IW'(NUM_ALLPASSES - 1));

  assign x      = 24'(send_r) <<< 5;
  assign cout   = c_rdata;
  assign st_cur = comb_damp[chan][cidx];
  assign diff   = 25'(st_cur) - 25'(cout);
  assign st_new = sat24(48'(out_w) + 48'(prod1 >>> 16));
  assign fb     = sat24(48'(x) + 48'(prod2 >>> 16));
  assign d      = a_rdata;
  assign ap_o   = sat24(48'(d) - 48'(v));
  assign ap_w   = sat24(48'(v) + 48'(d >>> 1));

  // Divide the comb sum by the comb count: reciprocal estimate, one correction.
  assign mag = sum[SUMW-1] ? SUMW'(-sum) : SUMW'(sum);
  assign q0  = dprod[SUMW+29:30];
  assign qn  = SUMW'(q0 * SUMW'(NUM_COMBS));
  assign r   = mag - qn;
  assign q   = (r >= SUMW'(NUM_COMBS)) ? q0 + SUMW'(1) : q0;

  assign scl = (57'(prodl) <<< 15) - 57'(prodl);
  assign scr = (57'(prodr) <<< 15) - 57'(prodr);

  assign wet_on   = (wet_gain != 16'd0);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  ssr_ram #(.WIDTH(24), .DEPTH(2 ** CAW)) u_comb_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_addr), .rdata(c_rdata)
  );

  ssr_ram #(.WIDTH(24), .DEPTH(2 ** AAW)) u_ap_ram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata), .raddr(a_addr), .rdata(a_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (needs_clear && wet_on) state_next = ST_CLEAR;
        else if (in_valid) state_next = wet_on ? ST_C_RD : ST_BYPASS;
      end
      ST_CLEAR:  if (&clr_addr) state_next = ST_IDLE;
      ST_BYPASS: if (out_free) state_next = ST_IDLE;
      ST_C_RD:   state_next = ST_C_MUL1;
      ST_C_MUL1: state_next = ST_C_MUL2;
      ST_C_MUL2: state_next = ST_C_WR;
      ST_C_WR:   state_next = c_last ? ST_DIV1 : ST_C_RD;
      ST_DIV1:   state_next = ST_DIV2;
      ST_DIV2:   state_next = ST_A_RD;
      ST_A_RD:   state_next = ST_A_WR;
      ST_A_WR: begin
        if (!a_last) state_next = ST_A_RD;
        else state_next = chan ? ST_MX1 : ST_C_RD;
      end
      ST_MX1:    state_next = ST_MX2;
      ST_MX2:    state_next = ST_MX3;
      ST_MX3:    state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Memory controls and input stall.
  always_comb begin
    in_stall = 1'b1;
    c_we     = 1'b0;
    a_we     = 1'b0;
    c_waddr  = c_addr;
    a_waddr  = a_addr;
    c_wdata  = fb;
    a_wdata  = ap_w;
    unique case (state)
      ST_IDLE:  in_stall = needs_clear && wet_on;
      ST_CLEAR: begin
        c_we    = ({1'b0, clr_addr} < (SW+1)'(2 ** CAW));
        a_we    = ({1'b0, clr_addr} < (SW+1)'(2 ** AAW));
        c_waddr = CAW'(clr_addr);
        a_waddr = AAW'(clr_addr);
        c_wdata = '0;
        a_wdata = '0;
      end
      ST_C_WR:  c_we = 1'b1;
      ST_A_WR:  a_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      needs_clear <= 1'b1;
      wet_gain    <= '0;
      decay_gain  <= DecayReset;
      mono_mode   <= 1'b0;
      clr_addr    <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_WET_GAIN:   wet_gain   <= cfg_data;
          REG_DECAY_GAIN: decay_gain <= cfg_data;
          REG_MONO_MODE:  mono_mode  <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept && !wet_on) needs_clear <= 1'b1;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + SW'(1);
        if (&clr_addr) needs_clear <= 1'b0;
      end
      if ((state == ST_DONE || state == ST_BYPASS) && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      send_r <= send_sample;
      el_r   <= existing_left;
      er_r   <= existing_right;
      last_r <= period_end;
      chan   <= 1'b0;
      idx    <= '0;
      sum    <= '0;
    end
    case (state)
      ST_CLEAR: begin
        for (int c = 0; c < 2; c++) begin
          for (int i = 0; i < NUM_COMBS; i++) begin
            comb_pos[c][i]  <= '0;
            comb_damp[c][i] <= '0;
          end
          for (int i = 0; i < NUM_ALLPASSES; i++) ap_pos[c][i] <= '0;
        end
      end
      ST_C_MUL1: begin
        out_w <= cout;
        sum   <= sum + SUMW'(cout);
        prod1 <= 41'(diff) * 41'sd18350;
      end
      ST_C_MUL2: begin
        comb_damp[chan][cidx] <= st_new;
        prod2 <= 41'(st_new) * $signed(41'({1'b0, decay_gain}));
      end
      ST_C_WR: begin
        comb_pos[chan][cidx] <= cpos_next;
        if (!c_last) idx <= idx + IW'(1);
      end
      ST_DIV1: dprod <= mag * DivRecip;
      ST_DIV2: begin
        v   <= sat24(sum[SUMW-1] ? -$signed(48'(q)) : $signed(48'(q)));
        idx <= '0;
      end
      ST_A_WR: begin
        ap_pos[chan][aidx] <= apos_next;
        v <= ap_o;
        if (!a_last) begin
          idx <= idx + IW'(1);
        end else if (!chan) begin
          tail_l <= ap_o;
          chan   <= 1'b1;
          idx    <= '0;
          sum    <= '0;
        end else begin
          tail_r <= ap_o;
        end
      end
      ST_MX1: prodl <= 41'(tail_l) * $signed(41'({1'b0, wet_gain}));
      ST_MX2: prodr <= 41'(tail_r) * $signed(41'({1'b0, wet_gain}));
      ST_MX3: begin
        tot_l <= mono_mode ? (58'(scl) + 58'(scr)) : 58'(scl);
        tot_r <= 58'(scr);
      end
      ST_DONE: begin
        if (out_free) begin
          left_out   <= mix_pcm(el_r, tot_l, mono_mode);
          right_out  <= mono_mode ? er_r : mix_pcm(er_r, tot_r, 1'b0);
          frame_last <= last_r;
        end
      end
      ST_BYPASS: begin
        if (out_free) begin
          left_out   <= el_r;
          right_out  <= er_r;
          frame_last <= last_r;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_no_dirty_start: assert property (@(posedge clk) disable iff (rst)
    accept |-> !(needs_clear && wet_on))
    else $error("item taken with tail enabled before lines were cleared");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE || $past(state) == ST_BYPASS))
    else $error("result raised outside a finishing state");

  a_comb_pos_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_C_WR) |-> (14'(cpos) < clen))
    else $error("comb position beyond line length");

  a_ap_pos_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_A_WR) |-> (14'(apos) < alen))
    else $error("allpass position beyond line length");

  a_start_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_C_RD && $past(state) == ST_IDLE) |-> !needs_clear)
    else $error("filter run started with clear pending");
`endif

endmodule

@@ rtl/ssr_ram.sv @@
// Generic simple dual-port RAM with registered read.
module ssr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ test/stereo_schroeder_reverb_top_tb.sv @@
// Self-checking testbench for the stereo reverb: random and directed frames.
module stereo_schroeder_reverb_top_tb import ssr_pkg::*;;

  localparam logic [1:0] RegUnused  = 2'd3;
  localparam int         IdleLimit  = 60000;
  localparam int         DrainWait  = 80;
  localparam int         DampQ16    = 18350;
  localparam int         LineSize   = 2048;
  localparam int         RightExtra = 23;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               last;
  } frame_t;

  class reverb_scoreboard;
    int     comb_mem[2][4][LineSize];
    int     comb_pos[2][4];
    int     damp_reg[2][4];
    int     ap_mem[2][2][LineSize];
    int     ap_pos[2][2];
    bit     dirty = 1'b1;
    int     wet = 0;
    int     decay = DecayReset;
    bit     mono = 1'b0;
    frame_t frame_q[$];
    int     errors = 0;

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_WET_GAIN:   wet = data;
        REG_DECAY_GAIN: decay = data;
        REG_MONO_MODE:  mono = data[0];
        default: ;
      endcase
    endfunction

    function void wipe();
      foreach (comb_mem[c, k, a]) comb_mem[c][k][a] = 0;
      foreach (ap_mem[c, k, a]) ap_mem[c][k][a] = 0;
      foreach (comb_pos[c, k]) begin
        comb_pos[c][k] = 0;
        damp_reg[c][k] = 0;
      end
      foreach (ap_pos[c, k]) ap_pos[c][k] = 0;
    endfunction

    function int clip24(longint v);
      if (v > 64'sd8388607) return 8388607;
      if (v < -64'sd8388608) return -8388608;
      return int'(v);
    endfunction

    function int line_len(int base, int ch);
      int n;
      n = base + (ch ? RightExtra : 0);
      return (n > LineSize) ? LineSize : n;
    endfunction

    function int channel_tail(int ch, int x);
      int     comb_lens[4];
      int     ap_lens[2];
      longint sum;
      int     v, p, n, tap, st, d, o;
      comb_lens = '{1237, 1381, 1481, 1601};
      ap_lens = '{601, 431};
      sum = 0;
      for (int k = 0; k < 4; k++) begin
        n = line_len(comb_lens[k], ch);
        p = comb_pos[ch][k];
        if (p >= n) p = 0;
        tap = comb_mem[ch][k][p];
        st = damp_reg[ch][k];
        st = clip24(longint'(tap) + (((longint'(st) - tap) * DampQ16) >>> 16));
        damp_reg[ch][k] = st;
        comb_mem[ch][k][p] = clip24(longint'(x) + ((longint'(st) * decay) >>> 16));
        p++;
        comb_pos[ch][k] = (p >= n) ? 0 : p;
        sum += tap;
      end
      v = clip24(sum / 4);
      for (int k = 0; k < 2; k++) begin
        n = line_len(ap_lens[k], ch);
        p = ap_pos[ch][k];
        if (p >= n) p = 0;
        d = ap_mem[ch][k][p];
        o = clip24(longint'(d) - v);
        ap_mem[ch][k][p] = clip24(longint'(v) + (d >>> 1));
        p++;
        ap_pos[ch][k] = (p >= n) ? 0 : p;
        v = o;
      end
      return v;
    endfunction

    function logic signed [15:0] mix(longint e, longint t, int sh);
      longint r;
      r = (e * (64'sd1 <<< sh) + t) / (64'sd1 <<< sh);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return 16'(r);
    endfunction

    function void note_input(int send, int el, int er, bit last);
      frame_t f;
      int     x, tl, tr;
      longint pl, pr;
      f.last = last;
      if (wet == 0) begin
        dirty = 1'b1;
        f.left = 16'(el);
        f.right = 16'(er);
      end else begin
        if (dirty) begin
          wipe();
          dirty = 1'b0;
        end
        x = clip24(longint'(send) * 32);
        tl = channel_tail(0, x);
        tr = channel_tail(1, x);
        pl = longint'(tl) * wet * 32767;
        pr = longint'(tr) * wet * 32767;
        if (mono) begin
          f.left = mix(el, pl + pr, 37);
          f.right = 16'(er);
        end else begin
          f.left = mix(el, pl, 36);
          f.right = mix(er, pr, 36);
        end
      end
      frame_q.push_back(f);
    endfunction

    function void check(frame_t got);
      frame_t exp_f;
      if (frame_q.size() == 0) begin
        $error("unexpected item: left %0d right %0d", got.left, got.right);
        errors++;
        return;
      end
      exp_f = frame_q.pop_front();
      if (got.left !== exp_f.left) begin
        $error("left_out: expected %0d, got %0d", exp_f.left, got.left);
        errors++;
      end
      if (got.right !== exp_f.right) begin
        $error("right_out: expected %0d, got %0d", exp_f.right, got.right);
        errors++;
      end
      if (got.last !== exp_f.last) begin
        $error("frame_last: expected %0b, got %0b", exp_f.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return frame_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [17:0] send_sample = '0;
  logic signed [15:0] existing_left = '0;
  logic signed [15:0] existing_right = '0;
  logic               period_end = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;
  logic               frame_last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  reverb_scoreboard sb = new();
  int  results_seen = 0;
  int  idle_cycles = 0;
  bit  no_gaps = 1'b0;

  stereo_schroeder_reverb_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: check results, stall on a changing pattern, one long hold-off.
  initial begin
    int mode;
    int span;
    mode = 0;
    span = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        sb.check('{left: left_out, right: right_out, last: frame_last});
        results_seen++;
        if (results_seen == 300) begin
          out_stall <= 1'b1;
          repeat (500) @(posedge clk);
        end
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 200);
      end
      span--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic send_frame(int send, int el, int er, bit last);
    in_valid <= 1'b1;
    send_sample <= 18'(send);
    existing_left <= 16'(el);
    existing_right <= 16'(er);
    period_end <= last;
    do @(posedge clk); while (in_stall);
    sb.note_input(send, el, er, last);
  endtask

  task automatic pause_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Mostly moderate sends so the tail stays audible, some full scale.
  function automatic int pick_send();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return $urandom_range(0, 8191) - 4096;
    if (sel < 85) return $signed(18'($urandom()));
    return sel[0] ? -131072 : 131071;
  endfunction

  task automatic random_frames(int count);
    int left_in_burst;
    left_in_burst = 0;
    for (int i = 0; i < count; i++) begin
      if (left_in_burst == 0) begin
        left_in_burst = $urandom_range(1, 24);
        no_gaps = ($urandom_range(0, 3) == 0);
        if (!no_gaps && i != 0) pause_sender($urandom_range(1, 30));
      end
      left_in_burst--;
      send_frame(pick_send(), $signed(16'($urandom())), $signed(16'($urandom())),
                 ($urandom_range(0, 7) == 0));
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_WET_GAIN, 16'hFFFF);
    write_reg(REG_DECAY_GAIN, 16'hFFFF);
    write_reg(REG_MONO_MODE, 16'd0);
    // Full-scale corners: drive the lines into saturation and the mix into clamp.
    send_frame(131071, 32767, -32768, 1'b1);
    send_frame(-131072, -32768, 32767, 1'b0);
    send_frame(0, 0, 0, 1'b0);
    send_frame(-1, -1, 1, 1'b1);
    for (int i = 0; i < 12; i++)
      send_frame(i[0] ? 131071 : -131072, i[1] ? 32767 : -32768,
                 i[2] ? 32767 : -32768, i[0]);
    for (int i = 0; i < 4; i++) send_frame(0, 32767, -32768, 1'b0);
    in_valid <= 1'b0;
    random_frames(230);

    // Tail disabled: passthrough and lines marked for clearing.
    write_reg(REG_WET_GAIN, 16'd0);
    send_frame(131071, 32767, -32768, 1'b1);
    random_frames(150);

    write_reg(RegUnused, 16'($urandom()));
    write_reg(REG_WET_GAIN, 16'd1);
    write_reg(REG_DECAY_GAIN, 16'd0);
    write_reg(REG_MONO_MODE, 16'd1);
    random_frames(200);

    write_reg(REG_WET_GAIN, 16'd20000);
    write_reg(REG_DECAY_GAIN, DecayReset);
    write_reg(REG_MONO_MODE, 16'd0);
    random_frames(150);
    // Hold the sender until every result is back.
    while (sb.pending() != 0) @(posedge clk);
    random_frames(150);

    write_reg(REG_WET_GAIN, 16'hFFFF);
    write_reg(REG_DECAY_GAIN, 16'd60000);
    write_reg(REG_MONO_MODE, 16'd1);
    random_frames(250);

    write_reg(REG_WET_GAIN, 16'd0);
    write_reg(REG_MONO_MODE, 16'd0);
    random_frames(100);

    write_reg(REG_WET_GAIN, 16'($urandom_range(1, 65535)));
    write_reg(REG_DECAY_GAIN, 16'($urandom()));
    random_frames(300);

    write_reg(REG_WET_GAIN, 16'd45000);
    write_reg(REG_DECAY_GAIN, 16'hFFFF);
    write_reg(REG_MONO_MODE, 16'd1);
    random_frames(200);

    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ stereo_schroeder_reverb_top.f @@
rtl/ssr_pkg.sv
rtl/ssr_ram.sv
rtl/stereo_schroeder_reverb_top.sv
test/stereo_schroeder_reverb_top_tb.sv
